// ===== rtl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and codes for the preemptive priority scheduler: item kinds,
// status codes, the process table entry and the controller/datapath links.
// ----------------------------------------------------------------------------
package pps_pkg;

  // Item kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_FULL       = 2'd1;
  localparam logic [1:0] STATUS_ZERO_BURST = 2'd2;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  // One process table row
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [15:0] remaining;
  } pps_entry_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic capture;      // latch the accepted item
    logic execute;      // act on clear / load
    logic scan_start;   // arm the table scan
    logic scan;         // scan in progress
    logic update;       // apply the tick to the chosen entry
    logic result_load;  // write the output register
  } pps_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic [1:0] kind;
    logic       tick_active;  // some loaded process not yet done
    logic       scan_done;
    logic       out_free;     // output register can take a result
  } pps_sts_t;

  // Time advance that sticks at the maximum
  function automatic logic [31:0] sat_inc(input logic [31:0] t);
    return (t == TIME_MAX) ? t : t + 32'd1;
  endfunction

endpackage

// ===== rtl/preemptive_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Preemptive priority scheduler simulated one time unit per tick transaction while loaded work remains.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall) carries kind, arrival_time,
//   burst_time and priority_req. kind selects clear, load or tick.
//   Output channel (result_valid / result_stall) returns exactly one result
//   transaction per input transaction, in order.
//   Clear, load and a tick with nothing left to run are captured, executed
//   and handed to the output register. A tick that has work scans the
//   loaded entries, at most MAX_PROCS, one per cycle through the single read
//   port of the process table, then updates the chosen entry before its
//   result is handed on. Only one transaction is in flight at a time;
//   item_stall is high from acceptance until its result enters the output
//   register. The output register holds a result while result_stall is high;
//   the next item may be accepted meanwhile, its result waits until the
//   register frees. After rst the table is empty, time is zero and no result
//   is pending. The table rows need no clearing; the done flags and counters
//   are reset.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] arrival_time,
  input  logic [15:0] burst_time,
  input  logic [7:0]  priority_req,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  output logic [4:0]  slot_process,
  output logic [31:0] slot_time,
  output logic        finished,
  output logic [31:0] turnaround,
  output logic [31:0] waiting,
  output logic        all_done
);

  pps_cmd_t cmd;
  pps_sts_t sts;

  // Sequencer
  pps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Table, counters and output register
  pps_datapath #(
    .MAX_PROCS (MAX_PROCS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .kind         (kind),
    .arrival_time (arrival_time),
    .burst_time   (burst_time),
    .priority_req (priority_req),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .slot_process (slot_process),
    .slot_time    (slot_time),
    .finished     (finished),
    .turnaround   (turnaround),
    .waiting      (waiting),
    .all_done     (all_done)
  );

`ifndef SYNTHESIS
  // An accepted transaction keeps the input stalled the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input not stalled after accepting a transaction");

  // A completion always names the process that ran
  a_finish_has_process: assert property (@(posedge clk) disable iff (rst)
    result_valid && finished |-> slot_process != 5'd0)
    else $error("finished result without a process id");

  // Rejected loads assign no id and complete nothing
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != STATUS_OK |-> slot_process == 5'd0 && !finished)
    else $error("rejected load carries an id or a completion");

  // Waiting never exceeds turnaround
  a_wait_le_tat: assert property (@(posedge clk) disable iff (rst)
    result_valid && finished |-> waiting <= turnaround)
    else $error("waiting time exceeds turnaround");
`endif

endmodule

// ===== rtl/pps_ctrl.sv =====
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer: accepts one transaction, runs clear/load or the tick scan and
// update in the datapath, then hands the result to the output register.
// ----------------------------------------------------------------------------
module pps_ctrl
  import pps_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_stall,
  input  pps_sts_t sts,
  output pps_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign item_stall = (state != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
        if (sts.kind == KIND_TICK && sts.tick_active) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/pps_datapath.sv =====
// ----------------------------------------------------------------------------
// pps_datapath
// Process table memory, counters, time, the one-entry-per-cycle best-ready
// search and the output register.
// ----------------------------------------------------------------------------
module pps_datapath
  import pps_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  pps_cmd_t    cmd,
  output pps_sts_t    sts,
  input  logic [1:0]  kind,
  input  logic [15:0] arrival_time,
  input  logic [15:0] burst_time,
  input  logic [7:0]  priority_req,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  output logic [4:0]  slot_process,
  output logic [31:0] slot_time,
  output logic        finished,
  output logic [31:0] turnaround,
  output logic [31:0] waiting,
  output logic        all_done
);

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  // Process table
  pps_entry_t table_mem [MAX_PROCS];
  pps_entry_t rd_data;

  // Latched item
  logic [1:0]  kind_r;
  logic [15:0] arr_r;
  logic [15:0] burst_r;
  logic [7:0]  prio_r;

  // Scheduler state
  logic [CNT_W-1:0]     entry_count;
  logic [CNT_W-1:0]     completed_count;
  logic [31:0]          current_time;
  logic [MAX_PROCS-1:0] done_flags;

  // Scan state
  logic [CNT_W-1:0] scan_idx;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;
  logic             found;
  logic [IDX_W-1:0] best_idx;
  pps_entry_t       best_word;

  // Result being built
  logic [1:0]  status_r;
  logic [4:0]  proc_r;
  logic [31:0] stime_r;
  logic        fin_r;
  logic [31:0] tat_r;

  logic             load_ok;
  logic             rd_en;
  logic             eligible;
  logic [15:0]      rem_new;
  logic [31:0]      comp_time;
  logic [CNT_W-1:0] new_id;
  logic [IDX_W:0]   best_id;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  pps_entry_t       mem_wdata;
  logic [31:0]      wait_val;

  assign load_ok  = (entry_count < CNT_W'(MAX_PROCS)) && (burst_r != 16'd0);
  assign rd_en    = cmd.scan && (scan_idx < entry_count);
  assign eligible = rd_valid && !done_flags[rd_idx]
                    && ({16'd0, rd_data.arrival} <= current_time)
                    && (!found || rd_data.prio < best_word.prio);
  assign rem_new   = (best_word.remaining == 16'd0) ? 16'd0 : best_word.remaining - 16'd1;
  assign comp_time = sat_inc(current_time);
  assign new_id    = entry_count + CNT_W'(1);
  assign best_id   = {1'b0, best_idx} + (IDX_W+1)'(1);
  assign wait_val  = (tat_r >= {16'd0, best_word.burst}) ? tat_r - {16'd0, best_word.burst}
                                                          : 32'd0;

  // Table write port: new entry on load, updated remaining time on tick
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = entry_count[IDX_W-1:0];
    mem_wdata = '{arrival: arr_r, burst: burst_r, prio: prio_r, remaining: burst_r};
    if (cmd.execute && kind_r == KIND_LOAD && load_ok) begin
      mem_we = 1'b1;
    end else if (cmd.update && found) begin
      mem_we              = 1'b1;
      mem_waddr           = best_idx;
      mem_wdata           = best_word;
      mem_wdata.remaining = rem_new;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= table_mem[scan_idx[IDX_W-1:0]];
    end
  end

  // Status to controller
  assign sts.kind        = kind_r;
  assign sts.tick_active = (completed_count < entry_count);
  assign sts.scan_done   = (scan_idx == entry_count) && !rd_valid;
  assign sts.out_free    = !result_valid || !result_stall;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count     <= '0;
      completed_count <= '0;
      current_time    <= '0;
      done_flags      <= '0;
      rd_valid        <= 1'b0;
      found           <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      if (cmd.execute && kind_r == KIND_CLEAR) begin
        entry_count     <= '0;
        completed_count <= '0;
        current_time    <= '0;
        done_flags      <= '0;
      end
      if (cmd.execute && kind_r == KIND_LOAD && load_ok) begin
        entry_count                          <= new_id;
        done_flags[entry_count[IDX_W-1:0]]   <= 1'b0;
      end
      if (cmd.scan_start) begin
        found    <= 1'b0;
        rd_valid <= 1'b0;
      end else if (cmd.scan) begin
        rd_valid <= rd_en;
        if (eligible) begin
          found <= 1'b1;
        end
      end
      if (cmd.update) begin
        current_time <= comp_time;
        if (found && rem_new == 16'd0) begin
          done_flags[best_idx] <= 1'b1;
          completed_count      <= completed_count + CNT_W'(1);
        end
      end
      if (cmd.result_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r   <= kind;
      arr_r    <= arrival_time;
      burst_r  <= burst_time;
      prio_r   <= priority_req;
      stime_r  <= current_time;
      status_r <= STATUS_OK;
      proc_r   <= 5'd0;
      fin_r    <= 1'b0;
      tat_r    <= 32'd0;
    end
    if (cmd.execute) begin
      if (kind_r == KIND_CLEAR) begin
        stime_r <= 32'd0;
      end else if (kind_r == KIND_LOAD) begin
        if (entry_count >= CNT_W'(MAX_PROCS)) begin
          status_r <= STATUS_FULL;
        end else if (burst_r == 16'd0) begin
          status_r <= STATUS_ZERO_BURST;
        end else begin
          proc_r <= 5'(new_id);
        end
      end
    end
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (rd_en) begin
      scan_idx <= scan_idx + CNT_W'(1);
    end
    if (rd_en) begin
      rd_idx <= scan_idx[IDX_W-1:0];
    end
    if (cmd.scan && eligible) begin
      best_idx  <= rd_idx;
      best_word <= rd_data;
    end
    if (cmd.update && found) begin
      proc_r <= 5'(best_id);
      if (rem_new == 16'd0) begin
        fin_r <= 1'b1;
        tat_r <= comp_time - {16'd0, best_word.arrival};
      end
    end
    // Output register
    if (cmd.result_load) begin
      status       <= status_r;
      slot_process <= proc_r;
      slot_time    <= stime_r;
      finished     <= fin_r;
      turnaround   <= tat_r;
      waiting      <= fin_r ? wait_val : 32'd0;
      all_done     <= (completed_count == entry_count);
    end
  end

endmodule
